### rtl/core/segint_pkg.sv
package segint_pkg;

    // Coordinate width of every endpoint field (two's complement).
    localparam int unsigned COORD_W = 16;
    // A coordinate difference needs one bit more than a coordinate.
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * DIFF_W;
    localparam int unsigned AREA_W  = PROD_W + 1;

    localparam int unsigned NUM_COORDS = 8;
    localparam int unsigned S_TDATA_W  = ((NUM_COORDS * COORD_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = 8;

    // Bit positions of the result fields in the master tdata.
    localparam int unsigned RES_TOUCH = 0;
    localparam int unsigned RES_CROSS = 1;

    // Index of each orientation in the lane arrays.
    localparam logic [1:0] ORI_ABC = 2'd0;
    localparam logic [1:0] ORI_ABD = 2'd1;
    localparam logic [1:0] ORI_CDA = 2'd2;
    localparam logic [1:0] ORI_CDB = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [AREA_W-1:0]  t_area;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by_coord;
        t_coord cx;
        t_coord cy;
        t_coord dx;
        t_coord dy;
    } t_seg_pair;

    // Operands of area(P,Q,R) = (Qx-Px)*(Ry-Py) - (Rx-Px)*(Qy-Py).
    typedef struct packed {
        t_diff qx_px;
        t_diff ry_py;
        t_diff rx_px;
        t_diff qy_py;
    } t_orient_in;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_sign;

    // Load enables of the four pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

### rtl/core/segint_front.sv
module segint_front (
    input  logic                                i_clk,
    input  segint_pkg::t_stage_en               i_en,
    input  segint_pkg::t_seg_pair               i_seg,
    output segint_pkg::t_orient_in [3:0]        o_ops,
    output logic [3:0]                          o_rng
);

    segint_pkg::t_orient_in [3:0] r_ops;
    segint_pkg::t_orient_in [3:0] n_ops;
    logic [3:0]                   r_rng;
    logic [3:0]                   n_rng;

    function automatic segint_pkg::t_diff sub(input segint_pkg::t_coord a,
                                               input segint_pkg::t_coord b);
        sub = {a[segint_pkg::COORD_W-1], a} - {b[segint_pkg::COORD_W-1], b};
    endfunction

    // Point r lies within the span of p..q, in x unless p and q share x.
    function automatic logic span(input segint_pkg::t_coord px, input segint_pkg::t_coord py,
                                  input segint_pkg::t_coord qx, input segint_pkg::t_coord qy,
                                  input segint_pkg::t_coord rx, input segint_pkg::t_coord ry);
        if (px != qx) begin
            span = (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
        end else begin
            span = (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
        end
    endfunction

    always_comb begin
        n_ops[segint_pkg::ORI_ABC] = '{sub(i_seg.bx, i_seg.ax), sub(i_seg.cy, i_seg.ay),
                                       sub(i_seg.cx, i_seg.ax), sub(i_seg.by_coord, i_seg.ay)};
        n_ops[segint_pkg::ORI_ABD] = '{sub(i_seg.bx, i_seg.ax), sub(i_seg.dy, i_seg.ay),
                                       sub(i_seg.dx, i_seg.ax), sub(i_seg.by_coord, i_seg.ay)};
        n_ops[segint_pkg::ORI_CDA] = '{sub(i_seg.dx, i_seg.cx), sub(i_seg.ay, i_seg.cy),
                                       sub(i_seg.ax, i_seg.cx), sub(i_seg.dy, i_seg.cy)};
        n_ops[segint_pkg::ORI_CDB] = '{sub(i_seg.dx, i_seg.cx), sub(i_seg.by_coord, i_seg.cy),
                                       sub(i_seg.bx, i_seg.cx), sub(i_seg.dy, i_seg.cy)};
        n_rng[segint_pkg::ORI_ABC] = span(i_seg.ax, i_seg.ay, i_seg.bx, i_seg.by_coord,
                                          i_seg.cx, i_seg.cy);
        n_rng[segint_pkg::ORI_ABD] = span(i_seg.ax, i_seg.ay, i_seg.bx, i_seg.by_coord,
                                          i_seg.dx, i_seg.dy);
        n_rng[segint_pkg::ORI_CDA] = span(i_seg.cx, i_seg.cy, i_seg.dx, i_seg.dy,
                                          i_seg.ax, i_seg.ay);
        n_rng[segint_pkg::ORI_CDB] = span(i_seg.cx, i_seg.cy, i_seg.dx, i_seg.dy,
                                          i_seg.bx, i_seg.by_coord);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ops <= n_ops;
            r_rng <= n_rng;
        end
    end

    assign o_ops = r_ops;
    assign o_rng = r_rng;

endmodule

### rtl/core/segint_orient.sv
module segint_orient (
    input  logic                   i_clk,
    input  segint_pkg::t_stage_en  i_en,
    input  segint_pkg::t_orient_in i_op,
    output segint_pkg::t_sign      o_sign
);

    segint_pkg::t_prod r_prod_p;
    segint_pkg::t_prod r_prod_q;
    segint_pkg::t_prod n_prod_p;
    segint_pkg::t_prod n_prod_q;
    segint_pkg::t_area n_area;
    segint_pkg::t_sign r_sign;
    segint_pkg::t_sign n_sign;

    always_comb begin
        n_prod_p = segint_pkg::t_prod'(i_op.qx_px) * segint_pkg::t_prod'(i_op.ry_py);
        n_prod_q = segint_pkg::t_prod'(i_op.rx_px) * segint_pkg::t_prod'(i_op.qy_py);
        n_area   = {r_prod_p[segint_pkg::PROD_W-1], r_prod_p}
                 - {r_prod_q[segint_pkg::PROD_W-1], r_prod_q};
        n_sign.neg  = n_area[segint_pkg::AREA_W-1];
        n_sign.zero = (n_area == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod_p <= n_prod_p;
            r_prod_q <= n_prod_q;
        end
        if (i_en.s3) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule

### rtl/core/segint_decide.sv
module segint_decide (
    input  logic                          i_clk,
    input  segint_pkg::t_stage_en         i_en,
    input  segint_pkg::t_sign [3:0]       i_sign,
    input  logic [3:0]                    i_rng,
    output logic                          o_touches,
    output logic                          o_crosses
);

    logic       r_touches;
    logic       r_crosses;
    logic       n_touches;
    logic       n_crosses;
    logic [3:0] pos;
    logic [3:0] zero;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            zero[i] = i_sign[i].zero;
            pos[i]  = !i_sign[i].neg && !i_sign[i].zero;
        end
        // Proper crossing: no collinear endpoint and both pairs straddle.
        n_crosses = (zero == 4'b0000)
                 && (pos[segint_pkg::ORI_ABC] != pos[segint_pkg::ORI_ABD])
                 && (pos[segint_pkg::ORI_CDA] != pos[segint_pkg::ORI_CDB]);
        n_touches = n_crosses || ((zero & i_rng) != 4'b0000);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_touches <= n_touches;
            r_crosses <= n_crosses;
        end
    end

    assign o_touches = r_touches;
    assign o_crosses = r_crosses;

endmodule

### rtl/core/segment_intersection_test_core.sv
// Channel   Direction  Handshake                Payload
// s_axis    in         i_s_tvalid / o_s_tready  i_s_tdata: ax ay bx by_coord cx cy dx dy
// m_axis    out        o_m_tvalid / i_m_tready  o_m_tdata: touches crosses_properly
//
// The result of a request passes through the four register stages (differences,
// products, area sign, decision) before it is valid at the output. One request can
// be accepted in every cycle unless a stall at the output has backed up into the
// first stage.
// Reset (synchronous, active low) clears only the stage valid bits.
// A stall at the output holds the last stage; earlier stages keep filling any
// empty slot, so bubbles close up and no request is lost or repeated.
module segment_intersection_test_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // Fields from bit 0 up: ax, ay, bx, by_coord, cx, cy, dx, dy.
    input  logic [segint_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // Fields from bit 0 up: touches, crosses_properly, zero fill.
    output logic [segint_pkg::M_TDATA_W-1:0]     o_m_tdata
);

    // Valid bits of the four stages travel alongside the data.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    segint_pkg::t_stage_en         stage_en;
    segint_pkg::t_seg_pair         seg;
    segint_pkg::t_orient_in [3:0]  ops;
    segint_pkg::t_sign [3:0]       signs;
    logic [3:0]                    rng1;
    // The endpoint span flags wait beside the multipliers and the area sign.
    logic [3:0]                    r_rng2;
    logic [3:0]                    r_rng3;
    logic                          touches;
    logic                          crosses;

    // A stage may load when it is empty or when the one after it moves on.
    assign rdy4 = !r_v4 || i_m_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign stage_en = '{s1: rdy1, s2: rdy2, s3: rdy3, s4: rdy4};
    assign o_s_tready = rdy1;

    // Unpack the coordinates; ax sits in the lowest bits.
    localparam int unsigned W = segint_pkg::COORD_W;
    assign seg.ax       = i_s_tdata[0*W +: W];
    assign seg.ay       = i_s_tdata[1*W +: W];
    assign seg.bx       = i_s_tdata[2*W +: W];
    assign seg.by_coord = i_s_tdata[3*W +: W];
    assign seg.cx       = i_s_tdata[4*W +: W];
    assign seg.cy       = i_s_tdata[5*W +: W];
    assign seg.dx       = i_s_tdata[6*W +: W];
    assign seg.dy       = i_s_tdata[7*W +: W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_rng2 <= rng1;
        end
        if (rdy3) begin
            r_rng3 <= r_rng2;
        end
    end

    segint_front u_front (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_seg (seg),
        .o_ops (ops),
        .o_rng (rng1)
    );

    // One multiplier pair and area sign per orientation: ABC, ABD, CDA, CDB.
    for (genvar g = 0; g < 4; g++) begin : g_orient
        segint_orient u_orient (
            .i_clk  (i_clk),
            .i_en   (stage_en),
            .i_op   (ops[g]),
            .o_sign (signs[g])
        );
    end

    segint_decide u_decide (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_sign    (signs),
        .i_rng     (r_rng3),
        .o_touches (touches),
        .o_crosses (crosses)
    );

    assign o_m_tvalid = r_v4;

    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[segint_pkg::RES_TOUCH] = touches;
        o_m_tdata[segint_pkg::RES_CROSS] = crosses;
    end

    // A proper crossing is always also a touch.
    a_cross_implies_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (touches || !crosses))
        else $error("crossing reported without touch");

    // An empty first stage never refuses a request.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> o_s_tready)
        else $error("input stalled with an empty first stage");

    // A request in stage three moves to the output when the output is free.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && rdy4) |=> r_v4)
        else $error("request dropped between stage three and the output");

    // A stalled result stays valid.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_m_tready) |=> (r_v4 && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule
